FILE: hdl/sci_pkg.sv
// shared widths, types and codes for the segment and circle intersection core
`timescale 1ns / 1ps
package sci_pkg;

	localparam int CW      = 32;            // coordinate width
	localparam int DW      = CW + 1;        // differences of coordinates
	localparam int PW      = 2 * DW;        // products of differences
	localparam int AW      = PW;            // squared segment length
	localparam int NW      = PW + 1;        // signed projection and cross terms
	localparam int RW      = CW - 1;        // radius
	localparam int R2W     = 2 * RW;        // squared radius
	localparam int HW      = AW / 2;        // half of a wide operand
	localparam int R2H     = R2W / 2;       // half of the squared radius
	localparam int AR2W    = AW + R2W;      // length times squared radius
	localparam int K2W     = 2 * (NW - 1);  // squared cross term
	localparam int DQW     = K2W + 1;       // discriminant, signed
	localparam int SW      = AR2W / 2;      // root of the discriminant
	localparam int NUMW    = DW + AW;       // divider numerator
	localparam int QB      = DW + 1;        // quotient magnitude bits
	localparam int QW      = QB + 1;        // signed quotient
	localparam int PTW     = CW + 2;        // point before saturation
	localparam int DIV_LAT = QB + 2;
	localparam int SQ_LAT  = SW + 1;
	localparam int QDEPTH  = 4;
	localparam int QAW     = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		QSEL_START,
		QSEL_END,
		QSEL_MID
	} qsel_t;

	typedef struct packed {
		logic signed [CW-1:0] x0, y0, x1, y1, cx, cy;
		logic [RW-1:0]        r;
		logic signed [DW-1:0] dx, dy, fx, fy;
		logic                 degen;
	} front_t;

	typedef struct packed {
		logic signed [CW-1:0]  x0, y0, x1, y1, cx, cy;
		logic signed [DW-1:0]  dx, dy;
		logic                  degen;
		logic [R2W-1:0]        r2;
		logic [AW-1:0]         a;
		logic signed [NW-1:0]  n;
		qsel_t                 qsel;
		logic [DQW-1:0]        dq;
		logic                  dq_neg;
		logic signed [PTW-1:0] qx, qy;
		logic                  s_lt, s_eq;
		logic                  keep1, keep2;
	} pipe_t;

endpackage

FILE: hdl/segment_circle_intersect_core.sv
// top level of the segment and circle intersection core
`timescale 1ns / 1ps
// usage
//   input channel: in_valid / in_ready carry one request, the two segment end
//   points and the circle centre as signed q16.16, the radius unsigned
//   output channel: out_valid / out_ready carry point_count (0 to 2) and up to
//   two points, the + root first; unused point fields read as zero
//   path: a request passes the closest point dividers, the square root and the
//   secant dividers in series, each divider 34 stages deep
//   throughput: one request per cycle while the back pipeline is not held
//   the front registers a request, a four-entry queue sits between it and the
//   back pipeline, so the front keeps taking requests while the back stalls
//   when out_ready is low while out_valid is high the whole back pipeline holds
//   and the queue fills, then in_ready falls; nothing is dropped
//   reset: arst_n clears every valid flag and the queue at once, no sweep
module segment_circle_intersect_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [sci_pkg::CW-1:0] start_x,
	input  logic signed [sci_pkg::CW-1:0] start_y,
	input  logic signed [sci_pkg::CW-1:0] end_x,
	input  logic signed [sci_pkg::CW-1:0] end_y,
	input  logic signed [sci_pkg::CW-1:0] center_x,
	input  logic signed [sci_pkg::CW-1:0] center_y,
	input  logic [sci_pkg::RW-1:0]        radius,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    point_count,
	output logic signed [sci_pkg::CW-1:0] first_x,
	output logic signed [sci_pkg::CW-1:0] first_y,
	output logic signed [sci_pkg::CW-1:0] second_x,
	output logic signed [sci_pkg::CW-1:0] second_y
);

	// front to queue
	logic            fr_valid, fr_ready;
	sci_pkg::front_t fr_data;
	// queue to back
	logic            bq_valid, bq_pop;
	sci_pkg::front_t bq_data;

	// differences and degenerate flag
	sci_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.center_x(center_x), .center_y(center_y), .radius(radius),
		.fr_valid(fr_valid), .fr_ready(fr_ready), .fr_data(fr_data)
	);

	// decouples the front from back pressure
	sci_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fr_valid), .wr_ready(fr_ready), .wr_data(fr_data),
		.rd_valid(bq_valid), .rd_ready(bq_pop), .rd_data(bq_data)
	);

	// the arithmetic, advancing as one whenever the output register frees
	sci_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(bq_valid), .q_pop(bq_pop), .q_data(bq_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.point_count(point_count),
		.first_x(first_x), .first_y(first_y),
		.second_x(second_x), .second_y(second_y)
	);

endmodule

FILE: hdl/sci_front.sv
// front stage: takes requests, forms differences and flags degenerate segments
`timescale 1ns / 1ps
module sci_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [sci_pkg::CW-1:0] start_x,
	input  logic signed [sci_pkg::CW-1:0] start_y,
	input  logic signed [sci_pkg::CW-1:0] end_x,
	input  logic signed [sci_pkg::CW-1:0] end_y,
	input  logic signed [sci_pkg::CW-1:0] center_x,
	input  logic signed [sci_pkg::CW-1:0] center_y,
	input  logic [sci_pkg::RW-1:0]        radius,
	output logic                          fr_valid,
	input  logic                          fr_ready,
	output sci_pkg::front_t               fr_data
);

	logic            valid_q;
	sci_pkg::front_t data_q;

	assign in_ready = !valid_q || fr_ready;
	assign fr_valid = valid_q;
	assign fr_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q.x0    <= start_x;
			data_q.y0    <= start_y;
			data_q.x1    <= end_x;
			data_q.y1    <= end_y;
			data_q.cx    <= center_x;
			data_q.cy    <= center_y;
			data_q.r     <= radius;
			data_q.dx    <= sci_pkg::DW'(end_x) - sci_pkg::DW'(start_x);
			data_q.dy    <= sci_pkg::DW'(end_y) - sci_pkg::DW'(start_y);
			data_q.fx    <= sci_pkg::DW'(start_x) - sci_pkg::DW'(center_x);
			data_q.fy    <= sci_pkg::DW'(start_y) - sci_pkg::DW'(center_y);
			data_q.degen <= (start_x == end_x) && (start_y == end_y);
		end
	end

endmodule

FILE: hdl/sci_queue.sv
// short request queue between the front and the back
`timescale 1ns / 1ps
module sci_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  sci_pkg::front_t wr_data,
	output logic            rd_valid,
	input  logic            rd_ready,
	output sci_pkg::front_t rd_data
);

	sci_pkg::front_t            mem_q [sci_pkg::QDEPTH];
	logic [sci_pkg::QAW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [sci_pkg::QAW:0]      cnt_q;
	logic                       push, pop;

	assign wr_ready = cnt_q != (sci_pkg::QAW+1)'(sci_pkg::QDEPTH);
	assign rd_valid = cnt_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (sci_pkg::QAW+1)'(sci_pkg::QDEPTH))
		else $error("queue fill beyond depth");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue fill did not rise on push");
	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue fill did not fall on pop");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");

endmodule

FILE: hdl/sci_div.sv
// pipelined restoring divider, one quotient bit a stage, rounded half away
`timescale 1ns / 1ps
module sci_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [sci_pkg::NUMW-1:0]      num,
	input  logic [sci_pkg::AW-1:0]        den,
	input  logic                          neg,
	output logic signed [sci_pkg::QW-1:0] quo
);

	localparam int RMW = sci_pkg::AW + 1;
	localparam int QB  = sci_pkg::QB;

	logic [RMW-1:0]          rem_s [0:QB];
	logic [QB-1:0]           low_s [0:QB];
	logic [QB-1:0]           qt_s  [0:QB];
	logic [sci_pkg::AW-1:0]  den_s [0:QB];
	logic                    neg_s [0:QB];
	logic                    rnd;
	logic [sci_pkg::QW-1:0]  mag;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= RMW'(num[sci_pkg::NUMW-1:QB]);
			low_s[0] <= num[QB-1:0];
			qt_s[0]  <= '0;
			den_s[0] <= den;
			neg_s[0] <= neg;
		end
	end

	for (genvar i = 1; i <= QB; i++) begin : g_stage
		logic [RMW-1:0] trial;
		logic           take;
		assign trial = {rem_s[i-1][RMW-2:0], low_s[i-1][QB-1]};
		assign take  = trial >= RMW'(den_s[i-1]);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= take ? trial - RMW'(den_s[i-1]) : trial;
				low_s[i] <= {low_s[i-1][QB-2:0], 1'b0};
				qt_s[i]  <= {qt_s[i-1][QB-2:0], take};
				den_s[i] <= den_s[i-1];
				neg_s[i] <= neg_s[i-1];
			end
		end
	end

	// twice the remainder against the divisor decides the rounding
	assign rnd = {rem_s[QB][RMW-2:0], 1'b0} >= RMW'(den_s[QB]);
	assign mag = sci_pkg::QW'(qt_s[QB]) + sci_pkg::QW'(rnd);

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= neg_s[QB] ? $signed(-mag) : $signed(mag);
		end
	end

endmodule

FILE: hdl/sci_sqrt.sv
// pipelined integer square root, one root bit a stage
`timescale 1ns / 1ps
module sci_sqrt (
	input  logic                       clk,
	input  logic                       en,
	input  logic [sci_pkg::AR2W-1:0]   val,
	output logic [sci_pkg::SW-1:0]     root
);

	localparam int SW   = sci_pkg::SW;
	localparam int VW   = sci_pkg::AR2W;
	localparam int REMW = SW + 3;

	logic [REMW-1:0] rem_s  [0:SW];
	logic [SW-1:0]   root_s [0:SW];
	logic [VW-1:0]   val_s  [0:SW];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			val_s[0]  <= val;
		end
	end

	for (genvar i = 1; i <= SW; i++) begin : g_stage
		logic [REMW-1:0] cur, test;
		logic            take;
		assign cur  = {rem_s[i-1][REMW-3:0], val_s[i-1][VW-1 -: 2]};
		assign test = {1'b0, root_s[i-1], 2'b01};
		assign take = cur >= test;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= take ? cur - test : cur;
				root_s[i] <= {root_s[i-1][SW-2:0], take};
				val_s[i]  <= {val_s[i-1][VW-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[SW];

endmodule

FILE: hdl/sci_back.sv
// back pipeline: closest point, distance test, discriminant root and secant points
`timescale 1ns / 1ps
module sci_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  sci_pkg::front_t               q_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    point_count,
	output logic signed [sci_pkg::CW-1:0] first_x,
	output logic signed [sci_pkg::CW-1:0] first_y,
	output logic signed [sci_pkg::CW-1:0] second_x,
	output logic signed [sci_pkg::CW-1:0] second_y
);

	localparam int CW   = sci_pkg::CW;
	localparam int DW   = sci_pkg::DW;
	localparam int PW   = sci_pkg::PW;
	localparam int AW   = sci_pkg::AW;
	localparam int NW   = sci_pkg::NW;
	localparam int HW   = sci_pkg::HW;
	localparam int R2H  = sci_pkg::R2H;
	localparam int NUMW = sci_pkg::NUMW;
	localparam int QW   = sci_pkg::QW;
	localparam int DL   = sci_pkg::DIV_LAT;
	localparam int SL   = sci_pkg::SQ_LAT;
	localparam int TOT  = 12 + 2 * DL + SL;

	function automatic logic signed [CW-1:0] sat_pt(input logic signed [QW:0] v);
		logic signed [QW:0] hi, lo;
		hi = (QW+1)'({1'b0, {(CW-1){1'b1}}});
		lo = -hi - 1'b1;
		if (v > hi)      sat_pt = hi[CW-1:0];
		else if (v < lo) sat_pt = lo[CW-1:0];
		else             sat_pt = v[CW-1:0];
	endfunction

	logic adv;
	logic [TOT-1:0] vl_q;
	logic ovalid_q;

	assign adv       = !ovalid_q || out_ready;
	assign q_pop     = adv && q_valid;
	assign out_valid = ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vl_q     <= '0;
			ovalid_q <= 1'b0;
		end else if (adv) begin
			vl_q     <= {vl_q[TOT-2:0], q_pop};
			ovalid_q <= vl_q[TOT-1];
		end
	end

	// stage 1: products of differences
	sci_pkg::pipe_t p0, p_s1;
	logic signed [PW-1:0] dxdx_s1, dydy_s1, fxdx_s1, fydy_s1, fxdy_s1, fydx_s1;

	always_comb begin
		p0       = '0;
		p0.x0    = q_data.x0;
		p0.y0    = q_data.y0;
		p0.x1    = q_data.x1;
		p0.y1    = q_data.y1;
		p0.cx    = q_data.cx;
		p0.cy    = q_data.cy;
		p0.dx    = q_data.dx;
		p0.dy    = q_data.dy;
		p0.degen = q_data.degen;
		p0.r2    = q_data.r * q_data.r;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1    <= p0;
			dxdx_s1 <= q_data.dx * q_data.dx;
			dydy_s1 <= q_data.dy * q_data.dy;
			fxdx_s1 <= q_data.fx * q_data.dx;
			fydy_s1 <= q_data.fy * q_data.dy;
			fxdy_s1 <= q_data.fx * q_data.dy;
			fydx_s1 <= q_data.fy * q_data.dx;
		end
	end

	// stage 2: length, projection and cross term
	sci_pkg::pipe_t p2c, p_s2;
	logic signed [NW-1:0] k_s2;

	always_comb begin
		p2c   = p_s1;
		p2c.a = AW'(dxdx_s1) + AW'(dydy_s1);
		p2c.n = -(NW'(fxdx_s1) + NW'(fydy_s1));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2 <= p2c;
			k_s2 <= NW'(fxdy_s1) - NW'(fydx_s1);
		end
	end

	// stage 3: closest point choice and partial products
	sci_pkg::pipe_t p3c, p_s3;
	logic [DW-1:0]   adx3, ady3;
	logic [AW-1:0]   nm3, ak3;
	logic [PW-1:0]   qxl_s3, qxh_s3, qyl_s3, qyh_s3;
	logic [HW+R2H-1:0] arll_s3, arlh_s3, arhl_s3, arhh_s3;
	logic [2*HW-1:0] kll_s3, klh_s3, khh_s3;

	always_comb begin
		p3c = p_s2;
		if (p_s2.degen || p_s2.n[NW-1]) begin
			p3c.qsel = sci_pkg::QSEL_START;
		end else if (p_s2.n[NW-2:0] > (NW-1)'(p_s2.a)) begin
			p3c.qsel = sci_pkg::QSEL_END;
		end else begin
			p3c.qsel = sci_pkg::QSEL_MID;
		end
		adx3 = p_s2.dx[DW-1] ? DW'(-p_s2.dx) : DW'(p_s2.dx);
		ady3 = p_s2.dy[DW-1] ? DW'(-p_s2.dy) : DW'(p_s2.dy);
		nm3  = p_s2.n[AW-1:0];
		ak3  = k_s2[NW-1] ? AW'(-k_s2) : AW'(k_s2);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s3    <= p3c;
			qxl_s3  <= adx3 * nm3[HW-1:0];
			qxh_s3  <= adx3 * nm3[AW-1:HW];
			qyl_s3  <= ady3 * nm3[HW-1:0];
			qyh_s3  <= ady3 * nm3[AW-1:HW];
			arll_s3 <= p_s2.a[HW-1:0] * p_s2.r2[R2H-1:0];
			arlh_s3 <= p_s2.a[HW-1:0] * p_s2.r2[2*R2H-1:R2H];
			arhl_s3 <= p_s2.a[AW-1:HW] * p_s2.r2[R2H-1:0];
			arhh_s3 <= p_s2.a[AW-1:HW] * p_s2.r2[2*R2H-1:R2H];
			kll_s3  <= ak3[HW-1:0] * ak3[HW-1:0];
			klh_s3  <= ak3[HW-1:0] * ak3[AW-1:HW];
			khh_s3  <= ak3[AW-1:HW] * ak3[AW-1:HW];
		end
	end

	// stage 4: sums of partial products
	sci_pkg::pipe_t p_s4;
	logic [NUMW-1:0]          numx_s4, numy_s4;
	logic [sci_pkg::AR2W-1:0] ar2_s4;
	logic [sci_pkg::K2W-1:0]  k2_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s4    <= p_s3;
			numx_s4 <= NUMW'(qxl_s3) + (NUMW'(qxh_s3) << HW);
			numy_s4 <= NUMW'(qyl_s3) + (NUMW'(qyh_s3) << HW);
			ar2_s4  <= sci_pkg::AR2W'(arll_s3) + (sci_pkg::AR2W'(arlh_s3) << R2H)
				+ (sci_pkg::AR2W'(arhl_s3) << HW) + (sci_pkg::AR2W'(arhh_s3) << (HW + R2H));
			k2_s4   <= sci_pkg::K2W'(kll_s3) + (sci_pkg::K2W'(klh_s3) << (HW + 1))
				+ (sci_pkg::K2W'(khh_s3) << (2 * HW));
		end
	end

	// stage 5: discriminant
	sci_pkg::pipe_t p5c, p_s5;
	logic [NUMW-1:0] numx_s5, numy_s5;

	always_comb begin
		p5c        = p_s4;
		p5c.dq     = sci_pkg::DQW'(ar2_s4) - sci_pkg::DQW'(k2_s4);
		p5c.dq_neg = p5c.dq[sci_pkg::DQW-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s5    <= p5c;
			numx_s5 <= numx_s4;
			numy_s5 <= numy_s4;
		end
	end

	// closest point division, side data delayed alongside
	logic signed [QW-1:0] qdx, qdy;
	sci_pkg::pipe_t d1_q [DL];

	sci_div u_div_qx (.clk(clk), .en(adv), .num(numx_s5), .den(p_s5.a),
		.neg(p_s5.dx[DW-1]), .quo(qdx));
	sci_div u_div_qy (.clk(clk), .en(adv), .num(numy_s5), .den(p_s5.a),
		.neg(p_s5.dy[DW-1]), .quo(qdy));

	always_ff @(posedge clk) begin
		if (adv) begin
			d1_q[0] <= p_s5;
			for (int i = 1; i < DL; i++) d1_q[i] <= d1_q[i-1];
		end
	end

	// stage 6: closest point
	sci_pkg::pipe_t p6c, p_s6;
	logic signed [QW:0] mx6, my6;

	always_comb begin
		p6c = d1_q[DL-1];
		mx6 = (QW+1)'(p6c.x0) + (QW+1)'(qdx);
		my6 = (QW+1)'(p6c.y0) + (QW+1)'(qdy);
		case (p6c.qsel)
			sci_pkg::QSEL_START: begin
				p6c.qx = sci_pkg::PTW'(p6c.x0);
				p6c.qy = sci_pkg::PTW'(p6c.y0);
			end
			sci_pkg::QSEL_END: begin
				p6c.qx = sci_pkg::PTW'(p6c.x1);
				p6c.qy = sci_pkg::PTW'(p6c.y1);
			end
			default: begin
				p6c.qx = mx6[sci_pkg::PTW-1:0];
				p6c.qy = my6[sci_pkg::PTW-1:0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) p_s6 <= p6c;
	end

	// stages 7 to 9: squared distance of the closest point
	sci_pkg::pipe_t p_s7, p_s8, p9c, p_s9;
	logic signed [DW-1:0] ex_s7, ey_s7;
	logic signed [PW-1:0] sqx_s8, sqy_s8;
	logic [PW:0]          ssum9;

	always_comb begin
		p9c      = p_s8;
		ssum9    = (PW+1)'(unsigned'(sqx_s8)) + (PW+1)'(unsigned'(sqy_s8));
		p9c.s_eq = ssum9 == (PW+1)'(p_s8.r2);
		p9c.s_lt = ssum9 < (PW+1)'(p_s8.r2);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s7   <= p_s6;
			ex_s7  <= DW'(p_s6.qx - sci_pkg::PTW'(p_s6.cx));
			ey_s7  <= DW'(p_s6.qy - sci_pkg::PTW'(p_s6.cy));
			p_s8   <= p_s7;
			sqx_s8 <= ex_s7 * ex_s7;
			sqy_s8 <= ey_s7 * ey_s7;
			p_s9   <= p9c;
		end
	end

	// square root of the discriminant
	logic [sci_pkg::SW-1:0]   sroot;
	logic [sci_pkg::AR2W-1:0] sq_in;
	sci_pkg::pipe_t d2_q [SL];

	assign sq_in = p_s9.dq_neg ? '0 : p_s9.dq[sci_pkg::AR2W-1:0];

	sci_sqrt u_sqrt (.clk(clk), .en(adv), .val(sq_in), .root(sroot));

	always_ff @(posedge clk) begin
		if (adv) begin
			d2_q[0] <= p_s9;
			for (int i = 1; i < SL; i++) d2_q[i] <= d2_q[i-1];
		end
	end

	// stage 10: both roots and whether they lie on the segment
	sci_pkg::pipe_t p10c, p_s10;
	logic signed [NW:0] n1c, n2c;
	logic [AW-1:0]      n1_s10, n2_s10;

	always_comb begin
		p10c       = d2_q[SL-1];
		n1c        = (NW+1)'(p10c.n) + {{(NW+1-sci_pkg::SW){1'b0}}, sroot};
		n2c        = (NW+1)'(p10c.n) - {{(NW+1-sci_pkg::SW){1'b0}}, sroot};
		p10c.keep1 = !n1c[NW] && (n1c[NW-1:0] <= NW'(p10c.a));
		p10c.keep2 = !n2c[NW] && (n2c[NW-1:0] <= NW'(p10c.a));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s10  <= p10c;
			n1_s10 <= n1c[AW-1:0];
			n2_s10 <= n2c[AW-1:0];
		end
	end

	// stages 11 and 12: secant numerators
	sci_pkg::pipe_t p_s11, p_s12;
	logic [DW-1:0] adx11, ady11;
	logic [PW-1:0] a1xl_s11, a1xh_s11, a1yl_s11, a1yh_s11;
	logic [PW-1:0] a2xl_s11, a2xh_s11, a2yl_s11, a2yh_s11;
	logic [NUMW-1:0] n1x_s12, n1y_s12, n2x_s12, n2y_s12;

	assign adx11 = p_s10.dx[DW-1] ? DW'(-p_s10.dx) : DW'(p_s10.dx);
	assign ady11 = p_s10.dy[DW-1] ? DW'(-p_s10.dy) : DW'(p_s10.dy);

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s11    <= p_s10;
			a1xl_s11 <= adx11 * n1_s10[HW-1:0];
			a1xh_s11 <= adx11 * n1_s10[AW-1:HW];
			a1yl_s11 <= ady11 * n1_s10[HW-1:0];
			a1yh_s11 <= ady11 * n1_s10[AW-1:HW];
			a2xl_s11 <= adx11 * n2_s10[HW-1:0];
			a2xh_s11 <= adx11 * n2_s10[AW-1:HW];
			a2yl_s11 <= ady11 * n2_s10[HW-1:0];
			a2yh_s11 <= ady11 * n2_s10[AW-1:HW];
			p_s12    <= p_s11;
			n1x_s12  <= NUMW'(a1xl_s11) + (NUMW'(a1xh_s11) << HW);
			n1y_s12  <= NUMW'(a1yl_s11) + (NUMW'(a1yh_s11) << HW);
			n2x_s12  <= NUMW'(a2xl_s11) + (NUMW'(a2xh_s11) << HW);
			n2y_s12  <= NUMW'(a2yl_s11) + (NUMW'(a2yh_s11) << HW);
		end
	end

	// secant divisions
	logic signed [QW-1:0] r1x, r1y, r2x, r2y;
	sci_pkg::pipe_t d3_q [DL];

	sci_div u_div_1x (.clk(clk), .en(adv), .num(n1x_s12), .den(p_s12.a),
		.neg(p_s12.dx[DW-1]), .quo(r1x));
	sci_div u_div_1y (.clk(clk), .en(adv), .num(n1y_s12), .den(p_s12.a),
		.neg(p_s12.dy[DW-1]), .quo(r1y));
	sci_div u_div_2x (.clk(clk), .en(adv), .num(n2x_s12), .den(p_s12.a),
		.neg(p_s12.dx[DW-1]), .quo(r2x));
	sci_div u_div_2y (.clk(clk), .en(adv), .num(n2y_s12), .den(p_s12.a),
		.neg(p_s12.dy[DW-1]), .quo(r2y));

	always_ff @(posedge clk) begin
		if (adv) begin
			d3_q[0] <= p_s12;
			for (int i = 1; i < DL; i++) d3_q[i] <= d3_q[i-1];
		end
	end

	// final assembly into the output register
	sci_pkg::pipe_t       pf;
	logic signed [CW-1:0] qpx, qpy, s1x, s1y, s2x, s2y;
	logic [1:0]           cnt_c;
	logic signed [CW-1:0] fx_c, fy_c, sx_c, sy_c;

	assign pf  = d3_q[DL-1];
	assign qpx = sat_pt((QW+1)'(pf.qx));
	assign qpy = sat_pt((QW+1)'(pf.qy));
	assign s1x = sat_pt((QW+1)'(pf.x0) + (QW+1)'(r1x));
	assign s1y = sat_pt((QW+1)'(pf.y0) + (QW+1)'(r1y));
	assign s2x = sat_pt((QW+1)'(pf.x0) + (QW+1)'(r2x));
	assign s2y = sat_pt((QW+1)'(pf.y0) + (QW+1)'(r2y));

	always_comb begin
		cnt_c = 2'd0;
		fx_c  = '0;
		fy_c  = '0;
		sx_c  = '0;
		sy_c  = '0;
		if (pf.s_eq) begin
			cnt_c = 2'd1;
			fx_c  = qpx;
			fy_c  = qpy;
		end else if (pf.s_lt && !pf.degen && !pf.dq_neg) begin
			if (pf.keep1 && pf.keep2) begin
				cnt_c = 2'd2;
				fx_c  = s1x;
				fy_c  = s1y;
				sx_c  = s2x;
				sy_c  = s2y;
			end else if (pf.keep1) begin
				cnt_c = 2'd1;
				fx_c  = s1x;
				fy_c  = s1y;
			end else if (pf.keep2) begin
				cnt_c = 2'd1;
				fx_c  = s2x;
				fy_c  = s2y;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			point_count <= cnt_c;
			first_x     <= fx_c;
			first_y     <= fy_c;
			second_x    <= sx_c;
			second_y    <= sy_c;
		end
	end

endmodule

FILE: dv/segment_circle_intersect_core_test.sv
// testbench for the segment and circle intersection core with a built-in predictor
`timescale 1ns / 1ps
module segment_circle_intersect_core_test;

	typedef logic signed [191:0] wide_t;

	typedef struct {
		logic signed [sci_pkg::CW-1:0] sx, sy, ex, ey, cx, cy;
		logic [sci_pkg::RW-1:0]        r;
	} query_t;

	typedef struct {
		logic [1:0]                    cnt;
		logic signed [sci_pkg::CW-1:0] ax, ay, bx, by;
	} points_t;

	// scoreboard: predicts the points of each accepted request, checks results in order
	class intersect_scoreboard;
		points_t expected_points[$];
		int      errors = 0;

		// quotient rounded to nearest, halves away from zero; den > 0
		function wide_t div_round(wide_t num, wide_t den);
			wide_t m, q;
			m = (num < 0) ? -num : num;
			q = m / den;
			if (2 * (m % den) >= den)
				q = q + 1;
			return (num < 0) ? -q : q;
		endfunction

		function wide_t isqrt(wide_t v);
			wide_t res, t;
			res = 0;
			for (int i = 80; i >= 0; i--) begin
				t = res | (wide_t'(1) << i);
				if (t * t <= v)
					res = t;
			end
			return res;
		endfunction

		function logic signed [sci_pkg::CW-1:0] clamp(wide_t v);
			if (v > 64'sh7FFF_FFFF)
				return 32'sh7FFF_FFFF;
			if (v < -64'sh8000_0000)
				return 32'sh8000_0000;
			return v[sci_pkg::CW-1:0];
		endfunction

		function points_t predict_points(query_t q);
			wide_t x0, y0, x1, y1, cx, cy, r2, dx, dy, fx, fy, a, nh, qx, qy, s, kc, dq, sr;
			wide_t px[2], py[2], roots[2];
			points_t p;
			int c;
			x0 = q.sx; y0 = q.sy; x1 = q.ex; y1 = q.ey; cx = q.cx; cy = q.cy;
			r2 = q.r;
			r2 = r2 * r2;
			c = 0;
			px[0] = 0; py[0] = 0; px[1] = 0; py[1] = 0;
			if (x0 == x1 && y0 == y1) begin
				if ((x0 - cx) * (x0 - cx) + (y0 - cy) * (y0 - cy) == r2) begin
					px[0] = x0; py[0] = y0; c = 1;
				end
			end else begin
				dx = x1 - x0; dy = y1 - y0; fx = x0 - cx; fy = y0 - cy;
				a = dx * dx + dy * dy;
				nh = -(fx * dx + fy * dy);
				if (nh < 0) begin
					qx = x0; qy = y0;
				end else if (nh > a) begin
					qx = x1; qy = y1;
				end else begin
					qx = x0 + div_round(dx * nh, a);
					qy = y0 + div_round(dy * nh, a);
				end
				s = (qx - cx) * (qx - cx) + (qy - cy) * (qy - cy);
				if (s == r2) begin
					px[0] = qx; py[0] = qy; c = 1;
				end else if (s < r2) begin
					kc = fx * dy - fy * dx;
					dq = a * r2 - kc * kc;
					if (dq >= 0) begin
						sr = isqrt(dq);
						roots[0] = nh + sr;
						roots[1] = nh - sr;
						for (int k = 0; k < 2; k++)
							if (roots[k] >= 0 && roots[k] <= a) begin
								px[c] = x0 + div_round(dx * roots[k], a);
								py[c] = y0 + div_round(dy * roots[k], a);
								c++;
							end
					end
				end
			end
			p.cnt = 2'(c);
			p.ax = (c >= 1) ? clamp(px[0]) : '0;
			p.ay = (c >= 1) ? clamp(py[0]) : '0;
			p.bx = (c >= 2) ? clamp(px[1]) : '0;
			p.by = (c >= 2) ? clamp(py[1]) : '0;
			return p;
		endfunction

		function void note_request(query_t q);
			expected_points.push_back(predict_points(q));
		endfunction

		function void compare(string name, longint exp_v, longint got_v);
			if (exp_v != got_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
			end
		endfunction

		function void check_result(points_t got);
			points_t e;
			if (expected_points.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual count %0d",
					$time, got.cnt);
				return;
			end
			e = expected_points.pop_front();
			compare("point_count", e.cnt, got.cnt);
			compare("first_x", e.ax, got.ax);
			compare("first_y", e.ay, got.ay);
			compare("second_x", e.bx, got.bx);
			compare("second_y", e.by, got.by);
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic signed [sci_pkg::CW-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic signed [sci_pkg::CW-1:0] center_x = '0, center_y = '0;
	logic [sci_pkg::RW-1:0]        radius = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [1:0]                    point_count;
	logic signed [sci_pkg::CW-1:0] first_x, first_y, second_x, second_y;

	intersect_scoreboard sb = new();
	int send_idle = 0;
	int recv_idle = 0;
	int quiet_cycles = 0;

	segment_circle_intersect_core DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure at the current idle rate
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle);

	// watch both channels at each edge
	always @(posedge clk) begin
		points_t got;
		query_t q;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				q.sx = start_x; q.sy = start_y; q.ex = end_x; q.ey = end_y;
				q.cx = center_x; q.cy = center_y; q.r = radius;
				sb.note_request(q);
			end
			if (out_valid && out_ready) begin
				got.cnt = point_count; got.ax = first_x; got.ay = first_y;
				got.bx = second_x; got.by = second_y;
				sb.check_result(got);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk)
		if (quiet_cycles >= 5000) begin
			$display("DONE: errors detected");
			$finish;
		end

	// one request: optional idle cycles, then hold valid until taken
	task automatic send_request(query_t q);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		start_x <= q.sx; start_y <= q.sy; end_x <= q.ex; end_y <= q.ey;
		center_x <= q.cx; center_y <= q.cy; radius <= q.r;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic send_shape(longint sx, longint sy, longint ex, longint ey,
			longint cx, longint cy, longint r);
		query_t q;
		q.sx = sci_pkg::CW'(sx); q.sy = sci_pkg::CW'(sy);
		q.ex = sci_pkg::CW'(ex); q.ey = sci_pkg::CW'(ey);
		q.cx = sci_pkg::CW'(cx); q.cy = sci_pkg::CW'(cy);
		q.r  = sci_pkg::RW'(r);
		send_request(q);
	endtask

	// mostly segments around a circle of random scale, some raw noise
	task automatic send_random();
		query_t q;
		longint cx, cy, r, span;
		if ($urandom_range(99) < 20) begin
			q.sx = $urandom; q.sy = $urandom; q.ex = $urandom; q.ey = $urandom;
			q.cx = $urandom; q.cy = $urandom; q.r = sci_pkg::RW'($urandom);
			send_request(q);
		end else begin
			r = $urandom & ((64'd1 << $urandom_range(2, 30)) - 1);
			cx = $signed($urandom);
			cy = $signed($urandom);
			if ($urandom_range(3) == 0) begin
				cx = cx >>> 8;
				cy = cy >>> 8;
			end
			span = 2 * r + 2;
			case ($urandom_range(4))
				0: send_shape(cx - r, cy + r, cx + r, cy + r, cx, cy, r); // tangent line
				1: send_shape(cx + r, cy, cx + r, cy, cx, cy, r);         // point on the circle
				default: send_shape(
					cx + $signed($urandom_range(0, span)) - span / 2 * 2,
					cy + $signed($urandom_range(0, span)) - span / 2 * 2,
					cx + 2 * $signed($urandom_range(0, span)) - span,
					cy + 2 * $signed($urandom_range(0, span)) - span,
					cx, cy, r);
			endcase
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed shapes, unit is one in q16.16
		send_shape(-65536, 0, 65536, 0, 0, 0, 32768);          // both roots on the segment
		send_shape(0, 0, 0, 0, 0, 0, 0);                       // degenerate, zero radius
		send_shape(65536, 0, 65536, 0, 0, 0, 65536);           // degenerate on the circle
		send_shape(65535, 0, 65535, 0, 0, 0, 65536);           // degenerate inside
		send_shape(-65536, 65536, 65536, 65536, 0, 0, 65536);  // tangent
		send_shape(-65536, 65537, 65536, 65537, 0, 0, 65536);  // just outside
		send_shape(0, 0, 10, 0, 0, 0, 65536);                  // wholly inside
		send_shape(0, 0, 131072, 0, 0, 0, 65536);              // exit root only
		send_shape(131072, 0, 0, 0, 0, 0, 65536);              // entry root only
		send_shape(200000, 5, 300000, 7, 0, 0, 65536);         // before the start
		send_shape(-300000, 5, -200000, 7, 0, 0, 65536);       // beyond the end
		send_shape(-2147483648, -2147483648, 2147483647, 2147483647, 0, 0, 2147483647);
		send_shape(2147483647, -2147483648, -2147483648, 2147483647, 0, 0, 2147483647);
		send_shape(-2147483648, -2147483648, -2147483648, -2147483648,
			2147483647, 2147483647, 2147483647);
		send_shape(2147483647, 2147483647, -2147483648, -2147483648,
			-2147483648, 2147483647, 2147483647);
		send_shape(-2147483648, 0, 2147483647, 0, 2147483647, 0, 0);
		send_shape(-1, -1, 1, 1, 0, 0, 1);
		send_shape(3, 4, 3, 4, 0, 0, 5);                       // degenerate exact hit
		send_shape(-10, 3, 10, 3, 0, 0, 5);                    // secant on small grid

		send_idle = 22; recv_idle = 50;
		repeat (310) send_random();
		send_idle = 50; recv_idle = 22;
		repeat (310) send_random();

		// hold off until the pipeline has drained
		in_valid <= 1'b0;
		while (sb.expected_points.size() != 0)
			@(posedge clk);

		send_idle = 0; recv_idle = 0;
		repeat (310) send_random();
		in_valid <= 1'b0;

		while (sb.expected_points.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
